@@ hw/rtl/two_priority_record_spool_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the two-priority record spool
// Clocked on clock, disabled during reset.
// ---------------------------------------------------------------------------
`ifndef TWO_PRIORITY_RECORD_SPOOL_MACROS_SVH
`define TWO_PRIORITY_RECORD_SPOOL_MACROS_SVH

// same-cycle implication
`define TPRS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TPRS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/tprs_pkg.sv @@
// ---------------------------------------------------------------------------
// tprs_pkg
// Shared types, command codes and the CRC-16 byte step for the record spool.
// ---------------------------------------------------------------------------
package tprs_pkg;

   localparam int LEN_W     = 10;
   localparam int HDR_BYTES = 11;

   localparam logic [2:0] CMD_BEGIN_NORMAL   = 3'd0;
   localparam logic [2:0] CMD_BEGIN_CRITICAL = 3'd1;
   localparam logic [2:0] CMD_PAYLOAD        = 3'd2;
   localparam logic [2:0] CMD_REPLAY         = 3'd3;
   localparam logic [2:0] CMD_CLEAR          = 3'd4;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_TOP  = 16'h8000;

   localparam logic [15:0] REPLAY_INTERVAL_RESET = 16'd100;

   typedef struct packed {
      logic [5:0]       pad;
      logic [31:0]      now_ms;
      logic [7:0]       data_byte;
      logic [LEN_W-1:0] length;
      logic [31:0]      timestamp;
      logic [31:0]      sequence_req;
   } req_type;

   typedef struct packed {
      logic [3:0]  pad;
      logic [31:0] replay_count;
      logic [31:0] drop_count;
      logic [3:0]  critical_count;
      logic [4:0]  normal_count;
      logic        record_done;
      logic [15:0] record_crc;
      logic [15:0] replayed_crc;
      logic [31:0] replayed_sequence;
      logic        replayed;
      logic        accepted;
   } rsp_type;

   typedef struct packed {
      logic [31:0] seq;
      logic [15:0] crc;
   } entry_type;

   typedef struct packed {
      logic clear;
      logic push;
      logic pop;
   } ring_ctl_type;

   typedef struct packed {
      logic start;
      logic byte_en;
   } crc_ctl_type;

   typedef struct packed {
      logic busy;
      logic last;
   } crc_sts_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] v;
      v = c ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if ((v & CRC_TOP) != 16'h0000) begin
            v = (v << 1) ^ CRC_POLY;
         end else begin
            v = v << 1;
         end
      end
      return v;
   endfunction

endpackage

@@ hw/rtl/two_priority_record_spool.sv @@
// ---------------------------------------------------------------------------
// two_priority_record_spool
// Normal and critical overwrite-oldest record rings with CRC-16 and replay.
// ---------------------------------------------------------------------------
// Usage: each req transfer carries one command in req_tuser (begin normal,
// begin critical, payload byte, replay, clear) with its header, byte and time
// in req_tdata. Every command gives exactly one rsp transfer with the status,
// the ring fills and the drop and replay counters after the command.
// The result is registered and appears in the cycle after the transfer; a
// popping replay reads the ring memory into the ring's read register and
// passes through S_READ to the output register. Payload bytes, clears and
// refused commands leave the block idle; an accepted begin holds it in S_HDR
// while the CRC unit folds the 11 header bytes in one byte per cycle.
// csr_wr_en writes the replay interval in milliseconds; write it only while
// the block is idle.
// Reset empties both rings, zeroes counters and times and sets the interval
// to 100. Ring memories hold no reset; only filled entries are ever read.
// When rsp_tready is low the result holds in the output register and
// req_tready drops until it is taken; nothing is lost.
// ---------------------------------------------------------------------------
`include "two_priority_record_spool_macros.svh"

module two_priority_record_spool
   import tprs_pkg::*;
#(
   parameter int NORMAL_DEPTH   = 16,
   parameter int CRITICAL_DEPTH = 8,
   parameter int MAX_PAYLOAD    = 512
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // sequence_req[31:0], timestamp[63:32], length[73:64], data_byte[81:74],
   // now_ms[113:82], zero fill[119:114]
   input  logic [119:0]  req_tdata,
   // command[2:0]
   input  logic [2:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // accepted[0], replayed[1], replayed_sequence[33:2], replayed_crc[49:34],
   // record_crc[65:50], record_done[66], normal_count[71:67],
   // critical_count[75:72], drop_count[107:76], replay_count[139:108],
   // zero fill[143:140]
   output logic [143:0]  rsp_tdata,
   input  logic          csr_wr_en,
   input  logic [15:0]   csr_wr_data
);

   localparam int NFW = $clog2(NORMAL_DEPTH + 1);
   localparam int CFW = $clog2(CRITICAL_DEPTH + 1);
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_HDR  = 2'd1;
   localparam logic [1:0] S_READ = 2'd2;

   req_type           req;
   logic              accept;
   logic [1:0]        state_ff, state_in;
   rsp_type           rsp_ff, rsp_in, res;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [15:0]       interval_ff;
   logic [31:0]       drops_ff, drops_in;
   logic [31:0]       replays_ff, replays_in;
   logic [31:0]       last_time_ff, last_time_in;
   logic [31:0]       last_seq_ff, last_seq_in;
   logic [31:0]       pend_seq_ff, pend_seq_in;
   logic [LEN_W-1:0]  bytes_left_ff, bytes_left_in;
   logic              crit_ff, crit_in;
   logic              full_len_ff, full_len_in;
   logic              sel_crit_ff, sel_crit_in;
   logic              begin_crit, begin_ok;
   logic              replay_due;
   logic [31:0]       elapsed;
   logic [7:0]        hash_byte;

   ring_ctl_type      n_ctl, c_ctl;
   entry_type         wr_entry, n_rd, c_rd;
   logic [NFW-1:0]    n_fill_next;
   logic [CFW-1:0]    c_fill_next;
   logic              n_full, c_full;
   logic              n_empty, c_empty;

   crc_ctl_type       crc_ctl;
   crc_sts_type       crc_sts;
   logic [15:0]       crc_next;
   logic [HDR_BYTES*8-1:0] header;

   assign req        = req_tdata;
   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   assign begin_crit = (req_tuser == CMD_BEGIN_CRITICAL);
   assign begin_ok   = (req.length != '0) && (req.length <= MAX_LEN) &&
                       !(!begin_crit && (req.sequence_req == last_seq_ff) &&
                         (last_seq_ff != 32'd0));
   assign header     = {7'd0, begin_crit, 6'd0, req.length, req.timestamp,
                        req.sequence_req};
   assign hash_byte  = ((bytes_left_ff == LEN_W'(1)) && full_len_ff) ? 8'd0 : req.data_byte;
   assign elapsed    = req.now_ms - last_time_ff;
   assign replay_due = (elapsed >= {16'd0, interval_ff});
   assign wr_entry   = '{seq: pend_seq_ff, crc: crc_next};

   always_comb begin
      state_in      = state_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      drops_in      = drops_ff;
      replays_in    = replays_ff;
      last_time_in  = last_time_ff;
      last_seq_in   = last_seq_ff;
      pend_seq_in   = pend_seq_ff;
      bytes_left_in = bytes_left_ff;
      crit_in       = crit_ff;
      full_len_in   = full_len_ff;
      sel_crit_in   = sel_crit_ff;
      n_ctl         = '0;
      c_ctl         = '0;
      crc_ctl       = '0;
      res           = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               case (req_tuser) inside
                  CMD_BEGIN_NORMAL, CMD_BEGIN_CRITICAL: begin
                     if (begin_ok) begin
                        if (!begin_crit) begin
                           last_seq_in = req.sequence_req;
                        end
                        bytes_left_in  = req.length;
                        pend_seq_in    = req.sequence_req;
                        crit_in        = begin_crit;
                        full_len_in    = (req.length == MAX_LEN);
                        crc_ctl.start  = 1'b1;
                        state_in       = S_HDR;
                        res.accepted   = 1'b1;
                     end else begin
                        bytes_left_in = '0;
                     end
                  end
                  CMD_PAYLOAD: begin
                     if (bytes_left_ff != '0) begin
                        crc_ctl.byte_en = 1'b1;
                        bytes_left_in   = bytes_left_ff - 1'b1;
                        res.accepted    = 1'b1;
                        if (bytes_left_ff == LEN_W'(1)) begin
                           res.record_done = 1'b1;
                           res.record_crc  = crc_next;
                           if (crit_ff) begin
                              c_ctl.push = 1'b1;
                           end else begin
                              n_ctl.push = 1'b1;
                              if (n_full) begin
                                 drops_in = drops_ff + 32'd1;
                              end
                           end
                        end
                     end
                  end
                  CMD_REPLAY: begin
                     if ((!n_empty || !c_empty) && replay_due) begin
                        last_time_in = req.now_ms;
                        replays_in   = replays_ff + 32'd1;
                        sel_crit_in  = !c_empty;
                        if (!c_empty) begin
                           c_ctl.pop = 1'b1;
                        end else begin
                           n_ctl.pop = 1'b1;
                        end
                        rsp_valid_in = 1'b0;
                        state_in     = S_READ;
                     end
                  end
                  CMD_CLEAR: begin
                     n_ctl.clear   = 1'b1;
                     c_ctl.clear   = 1'b1;
                     bytes_left_in = '0;
                     res.accepted  = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_HDR: begin
            if (crc_sts.last) begin
               state_in = S_IDLE;
            end
         end
         S_READ: begin
            res.replayed          = 1'b1;
            res.replayed_sequence = sel_crit_ff ? c_rd.seq : n_rd.seq;
            res.replayed_crc      = sel_crit_ff ? c_rd.crc : n_rd.crc;
            rsp_valid_in          = 1'b1;
            state_in              = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      res.normal_count   = 5'(n_fill_next);
      res.critical_count = 4'(c_fill_next);
      res.drop_count     = drops_in;
      res.replay_count   = replays_in;
      if (rsp_valid_in && !(rsp_valid_ff && !rsp_tready)) begin
         rsp_in = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         interval_ff   <= REPLAY_INTERVAL_RESET;
         drops_ff      <= '0;
         replays_ff    <= '0;
         last_time_ff  <= '0;
         last_seq_ff   <= '0;
         pend_seq_ff   <= '0;
         bytes_left_ff <= '0;
         crit_ff       <= 1'b0;
         full_len_ff   <= 1'b0;
         sel_crit_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            interval_ff <= csr_wr_data;
         end
         drops_ff      <= drops_in;
         replays_ff    <= replays_in;
         last_time_ff  <= last_time_in;
         last_seq_ff   <= last_seq_in;
         pend_seq_ff   <= pend_seq_in;
         bytes_left_ff <= bytes_left_in;
         crit_ff       <= crit_in;
         full_len_ff   <= full_len_in;
         sel_crit_ff   <= sel_crit_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   tprs_ring #(
      .DEPTH(NORMAL_DEPTH)
   ) u_normal_ring (
      .clock     (clock),
      .reset     (reset),
      .ctl       (n_ctl),
      .wr_entry  (wr_entry),
      .rd_entry  (n_rd),
      .fill_next (n_fill_next),
      .full      (n_full),
      .empty     (n_empty)
   );

   tprs_ring #(
      .DEPTH(CRITICAL_DEPTH)
   ) u_critical_ring (
      .clock     (clock),
      .reset     (reset),
      .ctl       (c_ctl),
      .wr_entry  (wr_entry),
      .rd_entry  (c_rd),
      .fill_next (c_fill_next),
      .full      (c_full),
      .empty     (c_empty)
   );

   tprs_crc u_crc (
      .clock    (clock),
      .reset    (reset),
      .ctl      (crc_ctl),
      .header   (header),
      .byte_in  (hash_byte),
      .crc_next (crc_next),
      .sts      (crc_sts)
   );

   `TPRS_ASSERT_NOW(a_hdr_busy, state_ff == S_HDR, crc_sts.busy, "header state without CRC work")
   `TPRS_ASSERT_NOW(a_read_slot_free, state_ff == S_READ, !rsp_valid_ff, "read with result held")
   `TPRS_ASSERT_NEXT(a_read_delivers, state_ff == S_READ, rsp_valid_ff && state_ff == S_IDLE, "replay result missing")
   `TPRS_ASSERT_NOW(a_bytes_bound, 1'b1, bytes_left_ff <= MAX_LEN, "byte count above maximum")
   `TPRS_ASSERT_NOW(a_crit_full_seen, c_ctl.push && c_full, c_fill_next == CFW'(CRITICAL_DEPTH), "critical push")

endmodule

@@ hw/rtl/tprs_ring.sv @@
// ---------------------------------------------------------------------------
// tprs_ring
// Overwrite-oldest ring of sequence/CRC entries in a one-port-read memory.
// ---------------------------------------------------------------------------
`include "two_priority_record_spool_macros.svh"

module tprs_ring
   import tprs_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  ring_ctl_type                   ctl,
   input  entry_type                      wr_entry,
   output entry_type                      rd_entry,
   output logic [$clog2(DEPTH+1)-1:0]     fill_next,
   output logic                           full,
   output logic                           empty
);

   localparam int AW = $clog2(DEPTH);
   localparam int FW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
   localparam logic [FW-1:0] FULL_CNT = FW'(DEPTH);
   localparam logic [FW:0]   DEPTH_W  = (FW+1)'(DEPTH);

   entry_type         mem [DEPTH];
   entry_type         rd_ff;
   logic [AW-1:0]     head_ff, head_in;
   logic [FW-1:0]     fill_ff, fill_in;
   logic [FW:0]       oldest_sum, oldest_wrap;
   logic [AW-1:0]     rd_addr;

   assign full        = (fill_ff == FULL_CNT);
   assign empty       = (fill_ff == '0);
   assign oldest_sum  = (FW+1)'(head_ff) + DEPTH_W - (FW+1)'(fill_ff);
   assign oldest_wrap = (oldest_sum >= DEPTH_W) ? oldest_sum - DEPTH_W : oldest_sum;
   assign rd_addr     = oldest_wrap[AW-1:0];
   assign rd_entry    = rd_ff;
   assign fill_next   = fill_in;

   always_comb begin
      head_in = head_ff;
      fill_in = fill_ff;
      if (ctl.clear) begin
         head_in = '0;
         fill_in = '0;
      end else if (ctl.push) begin
         head_in = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
         fill_in = full ? fill_ff : fill_ff + 1'b1;
      end else if (ctl.pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[head_ff] <= wr_entry;
      end
      if (ctl.pop) begin
         rd_ff <= mem[rd_addr];
      end
   end

   `TPRS_ASSERT_NOW(a_fill_bound, 1'b1, fill_ff <= FULL_CNT, "ring fill above depth")
   `TPRS_ASSERT_NOW(a_pop_nonempty, ctl.pop, fill_ff != '0, "pop from empty ring")
   `TPRS_ASSERT_NOW(a_push_pop_excl, ctl.push, !ctl.pop && !ctl.clear, "push collides")

endmodule

@@ hw/rtl/tprs_crc.sv @@
// ---------------------------------------------------------------------------
// tprs_crc
// CRC-16/CCITT-FALSE accumulator: header sequenced one byte per cycle,
// payload bytes folded in one per transfer.
// ---------------------------------------------------------------------------
module tprs_crc
   import tprs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  crc_ctl_type           ctl,
   input  logic [HDR_BYTES*8-1:0] header,
   input  logic [7:0]            byte_in,
   output logic [15:0]           crc_next,
   output crc_sts_type           sts
);

   localparam logic [3:0] HDR_CNT = 4'(HDR_BYTES);

   logic [15:0]            acc_ff, acc_in;
   logic [HDR_BYTES*8-1:0] sh_ff, sh_in;
   logic [3:0]             cnt_ff, cnt_in;

   assign crc_next = crc_byte(acc_ff, byte_in);
   assign sts.busy = (cnt_ff != 4'd0);
   assign sts.last = (cnt_ff == 4'd1);

   always_comb begin
      acc_in = acc_ff;
      sh_in  = sh_ff;
      cnt_in = cnt_ff;
      if (ctl.start) begin
         acc_in = CRC_INIT;
         sh_in  = header;
         cnt_in = HDR_CNT;
      end else if (sts.busy) begin
         acc_in = crc_byte(acc_ff, sh_ff[7:0]);
         sh_in  = sh_ff >> 8;
         cnt_in = cnt_ff - 4'd1;
      end else if (ctl.byte_en) begin
         acc_in = crc_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= CRC_INIT;
         cnt_ff <= 4'd0;
      end else begin
         acc_ff <= acc_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      sh_ff <= sh_in;
   end

endmodule
